>>> src/sql_like_matcher_top_macros.svh
// assertion macros shared by the matcher rtl
`ifndef SQL_LIKE_MATCHER_TOP_MACROS_SVH
`define SQL_LIKE_MATCHER_TOP_MACROS_SVH

// condition implies expression in the same cycle
`define SLM_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// condition implies expression in the next cycle
`define SLM_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

>>> src/slm_pkg.sv
// shared types and codes of the like-pattern matcher
package slm_pkg;

   // request kinds carried in req_tuser
   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_STRING = 2'd2;
   localparam logic [1:0] REQ_END    = 2'd3;

   // element kinds held in a cell
   localparam logic [1:0] KIND_LIT = 2'd0;
   localparam logic [1:0] KIND_ONE = 2'd1;
   localparam logic [1:0] KIND_RUN = 2'd2;

   localparam logic [7:0] BYTE_PCT   = 8'h25;
   localparam logic [7:0] BYTE_UND   = 8'h5F;
   localparam logic [7:0] ESC_RESET  = 8'h5C;

   // broadcast from the control to every cell
   typedef struct packed {
      logic       rearm;
      logic       step;
      logic [7:0] str_byte;
      logic [1:0] wr_kind;
      logic [7:0] wr_lit;
   } slm_ctrl_type;

   typedef struct packed {
      logic overflow;
      logic matched;
   } slm_rsp_type;

endpackage

>>> src/slm_cell.sv
// one pattern position: stored element, active bit, hand-off to the next position
module slm_cell #(
   parameter logic IS_FIRST = 1'b0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  slm_pkg::slm_ctrl_type ctrl,
   input  logic                 wr_en,
   input  logic                 elem_valid,
   input  logic                 closed,
   input  logic                 fwd_in,
   output logic                 fwd_out,
   output logic                 run_prop,
   output logic                 active
);
   import slm_pkg::*;

   logic [1:0] kind_ff;
   logic [7:0] lit_ff;
   logic       active_ff, active_in;
   logic       is_run, consume;

   assign is_run   = (kind_ff == KIND_RUN);
   assign run_prop = elem_valid & is_run;
   // a non-run element consumes one byte and hands the position on
   assign consume  = (kind_ff == KIND_ONE) || (lit_ff == ctrl.str_byte);
   assign fwd_out  = closed & elem_valid & ~is_run & consume;

   always_comb begin
      active_in = active_ff;
      if (ctrl.rearm) begin
         active_in = IS_FIRST;
      end else if (ctrl.step) begin
         active_in = (closed & run_prop) | fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= IS_FIRST;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         kind_ff <= ctrl.wr_kind;
         lit_ff  <= ctrl.wr_lit;
      end
   end

   assign active = active_ff;

endmodule

>>> src/slm_closure.sv
// run closure over the position row as one carry chain
module slm_closure #(
   parameter int WIDTH = 65
) (
   input  logic [WIDTH-1:0] act,
   input  logic [WIDTH-1:0] prop,
   output logic [WIDTH-1:0] closed
);
   logic [WIDTH-1:0] gen, sum, carry;

   // carry into bit j is set when an active position reaches j across runs
   assign gen    = act & prop;
   assign sum    = gen + prop;
   assign carry  = sum ^ gen ^ prop;
   assign closed = act | carry;

endmodule

>>> src/slm_rsp_queue.sv
// two-entry result queue between the matcher and the result channel
module slm_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  slm_pkg::slm_rsp_type push_data,
   output logic                full,
   output logic                out_valid,
   input  logic                out_ready,
   output slm_pkg::slm_rsp_type out_data
);
   import slm_pkg::*;

   logic        valid0_ff, valid0_in, valid1_ff, valid1_in;
   slm_rsp_type data0_ff, data0_in, data1_ff, data1_in;
   logic        pop;

   assign pop = valid0_ff & out_ready;

   always_comb begin
      valid0_in = valid0_ff;
      valid1_in = valid1_ff;
      data0_in  = data0_ff;
      data1_in  = data1_ff;
      if (pop) begin
         valid0_in = valid1_ff;
         data0_in  = data1_ff;
         valid1_in = 1'b0;
      end
      if (push) begin
         if (!valid0_in) begin
            valid0_in = 1'b1;
            data0_in  = push_data;
         end else begin
            valid1_in = 1'b1;
            data1_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
      end else begin
         valid0_ff <= valid0_in;
         valid1_ff <= valid1_in;
      end
   end

   always_ff @(posedge clock) begin
      data0_ff <= data0_in;
      data1_ff <= data1_in;
   end

   assign full      = valid1_ff;
   assign out_valid = valid0_ff;
   assign out_data  = data0_ff;

endmodule

>>> src/sql_like_matcher_top.sv
// top level of the like-pattern matcher
`include "sql_like_matcher_top_macros.svh"

// Matches byte strings against a like pattern held in a row of MAX_ELEMS cells.
// Each request item carries a kind in req_tuser: clear the pattern, append a
// pattern byte, feed a string byte, or end the string. '%' matches any run of
// bytes, '_' exactly one byte, and the escape byte (csr_wr_data, reset 0x5C)
// makes the next pattern byte literal; a lone trailing escape matches nothing.
// Elements past MAX_ELEMS are dropped and every later end of string reports
// overflow with no match until the next clear. Only end-of-string items give a
// result item. The block takes one item per clock cycle unless the result queue is
// full; that rate is set by the run closure, one carry chain across all MAX_ELEMS+1
// positions, followed by the per-cell step in the same cycle. A result is registered
// into a two-entry queue and waits there, so items keep flowing while one result
// is held. Appending or clearing restarts the string in progress. The user must
// write the escape byte only while the block is idle; the block does not enforce it.
module sql_like_matcher_top #(
   parameter int MAX_ELEMS = 64
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [1:0] req_tuser,   // [1:0] req_type
   // result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] matched, [1] overflow, [7:2] zero
   // escape byte register
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import slm_pkg::*;

   localparam int LW    = $clog2(MAX_ELEMS + 1);
   localparam int ALL_W = MAX_ELEMS + 1;

   // control state
   logic [7:0]    esc_ff;
   logic [LW-1:0] length_ff, length_in;
   logic          too_long_ff, too_long_in;
   logic          esc_pend_ff, esc_pend_in;
   logic          act_end_ff, act_end_in;

   logic          accept, is_clear, is_append, is_string, is_end;
   logic          push_elem, store_full;
   logic [1:0]    elem_kind;
   slm_ctrl_type  ctrl;
   slm_rsp_type   rsp_new, rsp_out;
   logic          queue_full;

   // position row
   logic [MAX_ELEMS-1:0] cell_act, cell_prop, cell_fwd, cell_wr, cell_valid;
   logic [ALL_W-1:0]     act_all, prop_all, closed_all;

   assign accept    = req_tvalid & req_tready;
   assign is_clear  = accept & (req_tuser == REQ_CLEAR);
   assign is_append = accept & (req_tuser == REQ_APPEND);
   assign is_string = accept & (req_tuser == REQ_STRING);
   assign is_end    = accept & (req_tuser == REQ_END);

   assign store_full = (length_ff == LW'(MAX_ELEMS));

   // an unescaped escape byte only arms the escape, everything else is an element
   assign push_elem = is_append & (esc_pend_ff | (req_tdata != esc_ff));

   always_comb begin
      if (esc_pend_ff) begin
         elem_kind = KIND_LIT;
      end else if (req_tdata == BYTE_PCT) begin
         elem_kind = KIND_RUN;
      end else if (req_tdata == BYTE_UND) begin
         elem_kind = KIND_ONE;
      end else begin
         elem_kind = KIND_LIT;
      end
   end

   always_comb begin
      ctrl.rearm    = is_clear | is_append | is_end;
      ctrl.step     = is_string;
      ctrl.str_byte = req_tdata;
      ctrl.wr_kind  = elem_kind;
      ctrl.wr_lit   = req_tdata;
   end

   always_comb begin
      length_in   = length_ff;
      too_long_in = too_long_ff;
      esc_pend_in = esc_pend_ff;
      if (is_clear) begin
         length_in   = '0;
         too_long_in = 1'b0;
         esc_pend_in = 1'b0;
      end else if (is_append) begin
         esc_pend_in = ~esc_pend_ff & (req_tdata == esc_ff);
         if (push_elem) begin
            if (store_full) begin
               too_long_in = 1'b1;
            end else begin
               length_in = length_ff + LW'(1);
            end
         end
      end
   end

   // final position has no element, it is only reached from the last cell
   always_comb begin
      act_end_in = act_end_ff;
      if (ctrl.rearm) begin
         act_end_in = 1'b0;
      end else if (ctrl.step) begin
         act_end_in = cell_fwd[MAX_ELEMS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff      <= ESC_RESET;
         length_ff   <= '0;
         too_long_ff <= 1'b0;
         esc_pend_ff <= 1'b0;
         act_end_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            esc_ff <= csr_wr_data;
         end
         length_ff   <= length_in;
         too_long_ff <= too_long_in;
         esc_pend_ff <= esc_pend_in;
         act_end_ff  <= act_end_in;
      end
   end

   // the row of cells, each handing its forward bit to the right neighbor
   for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
      assign cell_valid[i] = (LW'(i) < length_ff);
      assign cell_wr[i]    = push_elem & ~store_full & (length_ff == LW'(i));

      slm_cell #(
         .IS_FIRST (i == 0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .wr_en      (cell_wr[i]),
         .elem_valid (cell_valid[i]),
         .closed     (closed_all[i]),
         .fwd_in     ((i == 0) ? 1'b0 : cell_fwd[(i == 0) ? 0 : i - 1]),
         .fwd_out    (cell_fwd[i]),
         .run_prop   (cell_prop[i]),
         .active     (cell_act[i])
      );
   end

   assign act_all  = {act_end_ff, cell_act};
   assign prop_all = {1'b0, cell_prop};

   slm_closure #(
      .WIDTH (ALL_W)
   ) u_closure (
      .act    (act_all),
      .prop   (prop_all),
      .closed (closed_all)
   );

   // end of string: the position after the last element must be reachable
   assign rsp_new.matched  = closed_all[length_ff] & ~esc_pend_ff & ~too_long_ff;
   assign rsp_new.overflow = too_long_ff;

   slm_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (is_end),
      .push_data (rsp_new),
      .full      (queue_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_out)
   );

   assign req_tready = ~queue_full;
   assign rsp_tdata  = {6'b0, rsp_out.overflow, rsp_out.matched};

   // overflow is only flagged with a full store
   `SLM_ASSERT_NOW(a_overflow_full, too_long_ff, store_full, "overflow without full store")
   // rearming items leave only the start position active
   `SLM_ASSERT_NEXT(a_rearm_start, ctrl.rearm, act_all == ALL_W'(1), "rearm left stale positions")
   // no position beyond the pattern end is ever active
   `SLM_ASSERT_NOW(a_act_bound, 1'b1, ((act_all >> length_ff) >> 1) == '0,
      "active position beyond pattern end")
   // input stalls only while a result is waiting
   `SLM_ASSERT_NOW(a_stall_cause, !req_tready, rsp_tvalid, "input stalled with no result pending")

endmodule

>>> sim/tb_sql_like_matcher_top.sv
// self-checking testbench of the like-pattern matcher top level
module tb_sql_like_matcher_top;
   import slm_pkg::*;

   localparam int MAX_ELEMS    = 64;
   localparam int IDLE_LIMIT   = 1000;   // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 8;      // settle time after the last result
   localparam int MAX_PRINTS   = 50;     // mismatch lines printed, all are counted

   // one stored pattern element: what kind it is and its literal byte
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] lit;
   } pat_elem_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic [1:0] req_tuser = REQ_CLEAR;   // [1:0] req_type
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b1;
   logic [7:0] rsp_tdata;           // [0] matched, [1] overflow, [7:2] zero
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = ESC_RESET;

   sql_like_matcher_top #(
      .MAX_ELEMS(MAX_ELEMS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor state: the pattern as elements, the live position set and
   // the escape byte the block was last given
   // ---------------------------------------------------------------------
   pat_elem_type         pat_cells [MAX_ELEMS];
   int                   pat_len      = 0;
   bit                   pat_overflow = 1'b0;
   bit                   esc_armed    = 1'b0;
   bit [MAX_ELEMS:0]     live_pos     = {{MAX_ELEMS{1'b0}}, 1'b1};
   logic [7:0]           esc_byte     = ESC_RESET;

   slm_rsp_type          match_expect_q [$];

   // stimulus scratch: planned pattern elements and the bytes of one string
   pat_elem_type         plan_q [$];
   logic [7:0]           byte_q [$];

   bit  src_idle_on  = 1'b1;
   bit  sink_idle_on = 1'b1;
   int  items_sent   = 0;
   int  err_count    = 0;
   int  n_strings    = 0;
   int  n_hits       = 0;
   int  n_overflow   = 0;
   int  n_esc_values = 1;
   int  idle_cycles  = 0;
   int  sink_hold    = 0;

   // string restarts from its first position
   function automatic void restart_string();
      live_pos = {{MAX_ELEMS{1'b0}}, 1'b1};
   endfunction

   // any-run elements let an active position slide past them for free;
   // walking upward lets a chain of runs propagate in one pass
   function automatic void skip_runs();
      for (int i = 0; i < pat_len; i++) begin
         if (live_pos[i] && pat_cells[i].kind == KIND_RUN) live_pos[i + 1] = 1'b1;
      end
   endfunction

   function automatic void store_elem(logic [1:0] k, logic [7:0] b);
      if (pat_len < MAX_ELEMS) begin
         pat_cells[pat_len] = '{kind: k, lit: b};
         pat_len++;
      end else begin
         pat_overflow = 1'b1;
      end
   endfunction

   // advance the predictor by one accepted item, queue a result at end of string
   function automatic void predict_like_match(logic [1:0] kind, logic [7:0] data);
      bit [MAX_ELEMS:0]   nxt;
      slm_rsp_type        res;
      case (kind)
         REQ_CLEAR: begin
            pat_len      = 0;
            pat_overflow = 1'b0;
            esc_armed    = 1'b0;
            restart_string();
         end
         REQ_APPEND: begin
            // escape is tested ahead of the wildcards
            if (esc_armed) begin
               esc_armed = 1'b0;
               store_elem(KIND_LIT, data);
            end else if (data == esc_byte) begin
               esc_armed = 1'b1;
            end else if (data == BYTE_PCT) begin
               store_elem(KIND_RUN, data);
            end else if (data == BYTE_UND) begin
               store_elem(KIND_ONE, data);
            end else begin
               store_elem(KIND_LIT, data);
            end
            restart_string();
         end
         REQ_STRING: begin
            skip_runs();
            nxt = '0;
            for (int i = 0; i < pat_len; i++) begin
               if (live_pos[i]) begin
                  if (pat_cells[i].kind == KIND_RUN) nxt[i] = 1'b1;
                  else if (pat_cells[i].kind == KIND_ONE || pat_cells[i].lit == data)
                     nxt[i + 1] = 1'b1;
               end
            end
            live_pos = nxt;
         end
         default: begin
            skip_runs();
            res.matched  = live_pos[pat_len] && !esc_armed && !pat_overflow;
            res.overflow = pat_overflow;
            match_expect_q.push_back(res);
            n_strings++;
            if (res.matched) n_hits++;
            if (res.overflow) n_overflow++;
            restart_string();
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // handshake helpers
   // ---------------------------------------------------------------------

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap(bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // byte mix biased toward a tiny alphabet so literals actually hit
   function automatic logic [7:0] pick_byte();
      int         r;
      logic [7:0] v;
      r = $urandom_range(0, 9);
      if (r < 5) begin
         v = 8'($urandom_range(0, 2));
         return 8'h61 + v;
      end
      if (r < 7) begin
         v = 8'($urandom_range(0, 255));
         return v;
      end
      if (r == 7) return esc_byte;
      if (r == 8) return BYTE_PCT;
      return BYTE_UND;
   endfunction

   // send one item; valid stays high into the next call when no gap is drawn
   task automatic send_item(input logic [1:0] kind, input logic [7:0] data);
      int gap;
      gap = pick_gap(src_idle_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      predict_like_match(kind, data);
   endtask

   task automatic send_text(input logic [1:0] kind, input string s);
      for (int i = 0; i < s.len(); i++) send_item(kind, s[i]);
   endtask

   // stop sending and wait until every pending string has reported
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (match_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // escape byte only changes while nothing is in flight
   task automatic write_escape(input logic [7:0] b);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= b;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      esc_byte = b;
      n_esc_values++;
   endtask

   // ---------------------------------------------------------------------
   // random pattern and string generation
   // ---------------------------------------------------------------------

   // n < 0 draws a length: mostly short, some medium, a few full or too long
   task automatic make_plan(input int n);
      int           len;
      int           r;
      pat_elem_type e;
      plan_q.delete();
      if (n >= 0) begin
         len = n;
      end else begin
         r = $urandom_range(0, 19);
         if (r < 14) len = $urandom_range(0, 6);
         else if (r < 18) len = $urandom_range(7, 20);
         else if (r == 18) len = $urandom_range(40, MAX_ELEMS);
         else len = $urandom_range(MAX_ELEMS + 1, MAX_ELEMS + 4);
      end
      repeat (len) begin
         r = $urandom_range(0, 9);
         e.kind = (r < 5) ? KIND_LIT : (r < 7) ? KIND_ONE : KIND_RUN;
         e.lit  = pick_byte();
         plan_q.push_back(e);
      end
   endtask

   // encode the plan as pattern bytes, escaping literals that would be special
   task automatic send_pattern(input bit with_clear);
      if (with_clear) send_item(REQ_CLEAR, pick_byte());
      foreach (plan_q[i]) begin
         case (plan_q[i].kind)
            KIND_RUN: send_item(REQ_APPEND, BYTE_PCT);
            KIND_ONE: send_item(REQ_APPEND, BYTE_UND);
            default: begin
               if (plan_q[i].lit == BYTE_PCT || plan_q[i].lit == BYTE_UND ||
                   plan_q[i].lit == esc_byte)
                  send_item(REQ_APPEND, esc_byte);
               send_item(REQ_APPEND, plan_q[i].lit);
            end
         endcase
      end
      // now and then leave a dangling escape at the end
      if ($urandom_range(0, 11) == 0) send_item(REQ_APPEND, esc_byte);
   endtask

   // a string that fits the plan, sometimes damaged, sometimes pure noise
   task automatic make_string();
      int r;
      int idx;
      byte_q.delete();
      r = $urandom_range(0, 9);
      if (r < 7) begin
         foreach (plan_q[i]) begin
            case (plan_q[i].kind)
               KIND_LIT: byte_q.push_back(plan_q[i].lit);
               KIND_ONE: byte_q.push_back(pick_byte());
               default:  repeat ($urandom_range(0, 3)) byte_q.push_back(pick_byte());
            endcase
         end
         if ($urandom_range(0, 3) == 0) begin
            idx = $urandom_range(0, byte_q.size());
            case ($urandom_range(0, 2))
               0: if (idx < byte_q.size()) byte_q[idx] = pick_byte();
               1: if (idx < byte_q.size()) byte_q.delete(idx);
               default: byte_q.insert(idx, pick_byte());
            endcase
         end
      end else begin
         repeat ($urandom_range(0, 8)) byte_q.push_back(pick_byte());
      end
   endtask

   task automatic send_match_string();
      make_string();
      foreach (byte_q[i]) begin
         // rare pattern edit in the middle of a string
         if ($urandom_range(0, 59) == 0) send_item(REQ_APPEND, pick_byte());
         send_item(REQ_STRING, byte_q[i]);
      end
      send_item(REQ_END, pick_byte());
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // hand-picked corners under the reset escape byte
   task automatic test_directed_cases();
      // empty pattern against the empty string
      send_item(REQ_CLEAR, 8'h00);
      send_item(REQ_END, 8'hFF);
      // runs only, still empty string
      send_text(REQ_APPEND, "%%");
      send_item(REQ_END, 8'h00);
      // literal, any-one and trailing run
      send_item(REQ_CLEAR, 8'hFF);
      send_text(REQ_APPEND, "a_%");
      send_text(REQ_STRING, "ab");
      send_item(REQ_END, 8'h00);
      // escaped wildcard is a plain literal
      send_item(REQ_CLEAR, 8'h00);
      send_text(REQ_APPEND, "\\%");
      send_text(REQ_STRING, "%");
      send_item(REQ_END, 8'h00);
      // all-zero and all-one bytes in pattern and string
      send_item(REQ_CLEAR, 8'h00);
      send_item(REQ_APPEND, 8'h00);
      send_item(REQ_APPEND, 8'hFF);
      send_item(REQ_STRING, 8'h00);
      send_item(REQ_STRING, 8'hFF);
      send_item(REQ_END, 8'h00);
      // pattern edited mid-string, and it now ends in a lone escape
      send_item(REQ_STRING, 8'h00);
      send_item(REQ_APPEND, ESC_RESET);
      send_item(REQ_END, 8'h00);
   endtask

   task automatic test_random_traffic(input int budget);
      int start;
      start = items_sent;
      while (items_sent - start < budget) begin
         // some patterns run with no gaps on either side
         src_idle_on  = ($urandom_range(0, 3) != 0);
         sink_idle_on = ($urandom_range(0, 3) != 0);
         make_plan(-1);
         send_pattern($urandom_range(0, 11) != 0);
         repeat ($urandom_range(1, 4)) send_match_string();
      end
   endtask

   // store filled exactly, then past its end, then cleared again
   task automatic test_pattern_overflow();
      src_idle_on  = 1'b1;
      sink_idle_on = 1'b1;
      make_plan(MAX_ELEMS);
      send_pattern(1'b1);
      send_match_string();
      repeat (2) begin
         make_plan($urandom_range(MAX_ELEMS + 1, MAX_ELEMS + 6));
         send_pattern(1'b1);
         repeat (2) send_match_string();
      end
      make_plan(3);
      send_pattern(1'b1);
      send_match_string();
   endtask

   // escape byte at both extremes, on each wildcard, random, then back
   task automatic test_escape_settings();
      logic [7:0] esc_list [6];
      esc_list[0] = 8'h00;
      esc_list[1] = 8'hFF;
      esc_list[2] = BYTE_PCT;
      esc_list[3] = BYTE_UND;
      esc_list[4] = 8'($urandom_range(0, 255));
      esc_list[5] = ESC_RESET;
      foreach (esc_list[i]) begin
         write_escape(esc_list[i]);
         test_random_traffic(110);
      end
   endtask

   // ---------------------------------------------------------------------
   // result side: random backpressure and the checker
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         sink_hold  <= 0;
      end else if (sink_hold != 0) begin
         sink_hold <= sink_hold - 1;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         sink_hold  <= pick_gap(1'b1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string what, input logic [7:0] want,
                                  input logic [7:0] got);
      if (err_count < MAX_PRINTS)
         $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
      err_count++;
   endtask

   always @(posedge clock) begin : check_results
      slm_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (match_expect_q.size() == 0) begin
            report_mismatch("result with no string pending", 8'h00, rsp_tdata);
         end else begin
            want = match_expect_q.pop_front();
            if (rsp_tdata[0] !== want.matched)
               report_mismatch("matched", 8'(want.matched), 8'(rsp_tdata[0]));
            if (rsp_tdata[1] !== want.overflow)
               report_mismatch("overflow", 8'(want.overflow), 8'(rsp_tdata[1]));
            if (rsp_tdata[7:2] !== 6'd0)
               report_mismatch("pad bits", 8'h00, 8'(rsp_tdata[7:2]));
         end
      end
   end

   // watchdog: any stretch with no item moving on either side is a hang
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, match_expect_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_traffic(110);
      test_pattern_overflow();
      test_escape_settings();

      drain_results();
      if (match_expect_q.size() != 0)
         report_mismatch("results never delivered", 8'h00, 8'(match_expect_q.size()));

      $display("ran %0d items over %0d escape byte settings", items_sent, n_esc_values);
      $display("%0d strings checked: %0d matched, %0d against an overflowed pattern",
               n_strings, n_hits, n_overflow);
      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
